/* src/mandelbrot_pixel_classifier_top_macros.svh */
// Assertion macros used by the checker file of the pixel classifier.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef MANDELBROT_PIXEL_CLASSIFIER_TOP_MACROS_SVH
`define MANDELBROT_PIXEL_CLASSIFIER_TOP_MACROS_SVH

// The condition must hold at every clock edge.
`define MPC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the trigger holds, the condition must hold at the next clock edge.
`define MPC_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

/* src/mpc_pkg.sv */
package mpc_pkg;

	// Fixed-point format: signed, FRAC_BITS fraction bits, range [-16, 16).
	localparam int FRAC_BITS = 26;
	localparam int FX_W      = FRAC_BITS + 5;
	localparam int PROD_W    = 2 * FX_W;
	localparam int SQ_W      = PROD_W - FRAC_BITS;

	// Field and register widths.
	localparam int PIX_W      = 12;
	localparam int DIM_W      = 13;
	localparam int LIMIT_W    = 16;
	localparam int COLOR_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Coordinate divider: the real dividend is pixel_x*7 and the imaginary one pixel_y*2, both shifted by FRAC_BITS.
	localparam int DIV_NUM_W = PIX_W + 3 + FRAC_BITS;
	localparam int DIV_DEN_W = DIM_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	// Saturation input width, wide enough for every value that is clamped.
	localparam int SAT_W = DIV_NUM_W + 2;

	// Queue between the mapping front and the iteration back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 2'd2;

	localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST     = 13'd640;
	localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST    = 13'd400;
	localparam logic [LIMIT_W-1:0] ITERATION_LIMIT_RST = 16'd1000;

	localparam logic [COLOR_W-1:0] COLOR_INSIDE  = '0;
	localparam logic [COLOR_W-1:0] COLOR_OUTSIDE = '1;

	typedef logic signed [FX_W-1:0] fx_t;

	localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

	// A point c of the complex plane, handed from front to back.
	typedef struct packed {
		fx_t cr;
		fx_t ci;
	} mpc_point_t;

	// Fill status of the queue.
	typedef struct packed {
		logic full;
		logic empty;
	} mpc_q_stat_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV_RE,
		FR_DIV_IM,
		FR_PUSH
	} mpc_front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_CHK
	} mpc_back_state_t;

	// Clamp a wide signed value into the fixed-point range.
	function automatic fx_t fx_sat(logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = {{(SAT_W-FX_W){FX_MAX[FX_W-1]}}, FX_MAX};
		lo = {{(SAT_W-FX_W){FX_MIN[FX_W-1]}}, FX_MIN};
		if (v > hi) begin
			return FX_MAX;
		end else if (v < lo) begin
			return FX_MIN;
		end
		return v[FX_W-1:0];
	endfunction

endpackage

/* src/mpc_front.sv */
module mpc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [mpc_pkg::PIX_W-1:0]      pixel_x,
	input  logic [mpc_pkg::PIX_W-1:0]      pixel_y,
	input  logic [mpc_pkg::DIM_W-1:0]      image_width,
	input  logic [mpc_pkg::DIM_W-1:0]      image_height,
	input  mpc_pkg::mpc_q_stat_t           q_stat,
	output logic                           busy,
	output logic                           push,
	output mpc_pkg::mpc_point_t            point
);
	import mpc_pkg::*;

	mpc_front_state_t state_q, state_nx;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] dq_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [PIX_W-1:0]     py_q;
	fx_t                  cr_q;
	fx_t                  ci_q;

	logic [DIV_DEN_W:0]   rem_sh;
	logic                 q_bit;
	logic [DIV_DEN_W-1:0] rem_nx;
	logic [DIV_NUM_W-1:0] dq_nx;
	logic                 div_last;
	logic [PIX_W+2:0]     px7;
	logic [DIM_W-1:0]     w_eff;
	logic [DIM_W-1:0]     h_eff;
	logic signed [SAT_W-1:0] re_wide;
	logic signed [SAT_W-1:0] im_wide;

	localparam logic signed [SAT_W-1:0] RE_OFFSET = SAT_W'(5) <<< (FRAC_BITS - 1);
	localparam logic signed [SAT_W-1:0] IM_OFFSET = SAT_W'(1) <<< FRAC_BITS;

	// One restoring division step: bring in the next dividend bit, subtract if it fits.
	always_comb begin
		rem_sh   = {rem_q, dq_q[DIV_NUM_W-1]};
		q_bit    = (rem_sh >= {1'b0, den_q});
		rem_nx   = q_bit ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
		dq_nx    = {dq_q[DIV_NUM_W-2:0], q_bit};
		div_last = (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1));
	end

	// Divisor and dividend preparation and quotient offsets; a zero dimension counts as one.
	always_comb begin
		px7     = ({3'b000, pixel_x} << 3) - {3'b000, pixel_x};
		w_eff   = (image_width == '0) ? DIM_W'(1) : image_width;
		h_eff   = (image_height == '0) ? DIM_W'(1) : image_height;
		re_wide = $signed({2'b00, dq_nx}) - RE_OFFSET;
		im_wide = $signed({2'b00, dq_nx}) - IM_OFFSET;
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			FR_IDLE: begin
				if (start) state_nx = FR_DIV_RE;
			end
			FR_DIV_RE: begin
				if (div_last) state_nx = FR_DIV_IM;
			end
			FR_DIV_IM: begin
				if (div_last) state_nx = FR_PUSH;
			end
			FR_PUSH: begin
				if (!q_stat.full) state_nx = FR_IDLE;
			end
			default: state_nx = FR_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		busy     = (state_q != FR_IDLE);
		push     = (state_q == FR_PUSH) && !q_stat.full;
		point.cr = cr_q;
		point.ci = ci_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Divider datapath: real part first, then imaginary part.
	always_ff @(posedge clk) begin
		unique case (state_q)
			FR_IDLE: begin
				if (start) begin
					dq_q  <= {px7, {FRAC_BITS{1'b0}}};
					den_q <= {w_eff, 1'b0};
					rem_q <= '0;
					cnt_q <= '0;
					py_q  <= pixel_y;
				end
			end
			FR_DIV_RE: begin
				if (div_last) begin
					cr_q  <= fx_sat(re_wide);
					dq_q  <= {2'b00, py_q, 1'b0, {FRAC_BITS{1'b0}}};
					den_q <= {1'b0, h_eff};
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					dq_q  <= dq_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			FR_DIV_IM: begin
				dq_q  <= dq_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q + 1'b1;
				if (div_last) ci_q <= fx_sat(im_wide);
			end
			FR_PUSH: begin
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/mpc_queue.sv */
module mpc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mpc_pkg::mpc_point_t   push_data,
	input  logic                  pop,
	output mpc_pkg::mpc_point_t   pop_data,
	output mpc_pkg::mpc_q_stat_t  stat
);
	import mpc_pkg::*;

	mpc_point_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   fill_q;

	// Status and head of the queue.
	always_comb begin
		stat.full  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
		stat.empty = (fill_q == '0);
		pop_data   = mem_q[rptr_q];
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)  rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

endmodule

/* src/mpc_back.sv */
module mpc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mpc_pkg::mpc_q_stat_t          q_stat,
	input  mpc_pkg::mpc_point_t           pop_data,
	input  logic [mpc_pkg::LIMIT_W-1:0]   iteration_limit,
	output logic                          pop,
	output logic                          done,
	output logic [mpc_pkg::COLOR_W-1:0]   color
);
	import mpc_pkg::*;

	localparam logic signed [SQ_W:0] ESC_BOUND = (SQ_W+1)'(4) <<< FRAC_BITS;

	mpc_back_state_t state_q, state_nx;

	fx_t                 cr_q;
	fx_t                 ci_q;
	fx_t                 x_q;
	fx_t                 y_q;
	logic [LIMIT_W-1:0]  cnt_q;
	logic signed [PROD_W-1:0] pxx_s1;
	logic signed [PROD_W-1:0] pyy_s1;
	logic signed [PROD_W-1:0] pxy_s1;
	logic                done_q;
	logic [COLOR_W-1:0]  color_q;

	logic signed [SQ_W-1:0]  xx;
	logic signed [SQ_W-1:0]  yy;
	logic signed [SQ_W:0]    xy2;
	logic signed [SQ_W:0]    mag;
	logic                    escape;
	logic                    limit_hit;
	logic                    finish;
	logic signed [SAT_W-1:0] nx_wide;
	logic signed [SAT_W-1:0] ny_wide;

	// Scale the registered products back, test the escape and limit conditions and form the next z.
	always_comb begin
		xx        = $signed(pxx_s1[PROD_W-1:FRAC_BITS]);
		yy        = $signed(pyy_s1[PROD_W-1:FRAC_BITS]);
		xy2       = $signed(pxy_s1[PROD_W-1:FRAC_BITS-1]);
		mag       = (SQ_W+1)'(xx) + (SQ_W+1)'(yy);
		escape    = (mag > ESC_BOUND);
		limit_hit = (cnt_q >= iteration_limit);
		finish    = escape || limit_hit;
		nx_wide   = SAT_W'(xx) - SAT_W'(yy) + SAT_W'(cr_q);
		ny_wide   = SAT_W'(xy2) + SAT_W'(ci_q);
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) state_nx = BK_MUL;
			end
			BK_MUL: state_nx = BK_CHK;
			BK_CHK: state_nx = finish ? BK_IDLE : BK_MUL;
			default: state_nx = BK_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		pop   = (state_q == BK_IDLE) && !q_stat.empty;
		done  = done_q;
		color = color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == BK_CHK) && finish;
		end
	end

	// Iteration datapath: products registered in BK_MUL, then tested and z updated in BK_CHK.
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					cr_q  <= pop_data.cr;
					ci_q  <= pop_data.ci;
					x_q   <= '0;
					y_q   <= '0;
					cnt_q <= '0;
				end
			end
			BK_MUL: begin
				pxx_s1 <= x_q * x_q;
				pyy_s1 <= y_q * y_q;
				pxy_s1 <= x_q * y_q;
			end
			BK_CHK: begin
				if (finish) begin
					color_q <= (cnt_q == iteration_limit) ? COLOR_INSIDE : COLOR_OUTSIDE;
				end else begin
					x_q   <= fx_sat(nx_wide);
					y_q   <= fx_sat(ny_wide);
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/mandelbrot_pixel_classifier_top.sv */
// Escape-time pixel classifier. A pixel (pixel_x, pixel_y) is taken when start is high and
// busy is low; the mapping divider then holds busy high through both divisions and the push
// into the queue, which waits while the queue is full, before it can take the next pixel, while
// a two-entry queue feeds the iteration engine. The engine loads a point and then, for each
// iteration, multiplies and then tests and updates, so the time a pixel occupies it grows
// with its iterations; the sustained rate is therefore set by the iteration loop, slowest
// for pixels inside the set, which run to iteration_limit. Each result appears on red, green
// and blue for exactly one cycle with done high, in the order the pixels were taken; the
// receiver cannot stall it and must take it in that cycle.
// Configuration writes are always accepted (cfg_ready is high) and must be issued only while no
// pixel is in flight.
module mandelbrot_pixel_classifier_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [mpc_pkg::PIX_W-1:0]        pixel_x,
	input  logic [mpc_pkg::PIX_W-1:0]        pixel_y,
	output logic                             done,
	output logic [mpc_pkg::COLOR_W-1:0]      red,
	output logic [mpc_pkg::COLOR_W-1:0]      green,
	output logic [mpc_pkg::COLOR_W-1:0]      blue,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mpc_pkg::*;

	logic [DIM_W-1:0]   image_width_q;
	logic [DIM_W-1:0]   image_height_q;
	logic [LIMIT_W-1:0] iteration_limit_q;

	logic          push;
	logic          pop;
	mpc_point_t    push_data;
	mpc_point_t    pop_data;
	mpc_q_stat_t   q_stat;
	logic [COLOR_W-1:0] color;

	assign cfg_ready = 1'b1;

	// Configuration registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q     <= IMAGE_WIDTH_RST;
			image_height_q    <= IMAGE_HEIGHT_RST;
			iteration_limit_q <= ITERATION_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:     image_width_q     <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:    image_height_q    <= cfg_data[DIM_W-1:0];
				REG_ITERATION_LIMIT: iteration_limit_q <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Coordinate mapping.
	mpc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.q_stat       (q_stat),
		.busy         (busy),
		.push         (push),
		.point        (push_data)
	);

	// Points waiting for the iteration engine.
	mpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// Escape-time iteration.
	mpc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_stat          (q_stat),
		.pop_data        (pop_data),
		.iteration_limit (iteration_limit_q),
		.pop             (pop),
		.done            (done),
		.color           (color)
	);

	assign red   = color;
	assign green = color;
	assign blue  = color;

endmodule

/* src/mpc_checker.sv */
`include "mandelbrot_pixel_classifier_top_macros.svh"

module mpc_top_props (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [mpc_pkg::COLOR_W-1:0]   red,
	input logic [mpc_pkg::COLOR_W-1:0]   green,
	input logic [mpc_pkg::COLOR_W-1:0]   blue
);
	import mpc_pkg::*;

	logic color_ok;

	// A result is either black or white, the same on all three channels.
	assign color_ok = (red == green) && (green == blue)
		&& ((red == COLOR_INSIDE) || (red == COLOR_OUTSIDE));

	// A taken pixel occupies the mapping front in the following cycle.
	`MPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after a pixel was taken")

	// After a result the engine returns to idle before its next test, so results never come back to back.
	`MPC_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held for two cycles")

	// Every result carries a legal color.
	`MPC_ASSERT_ALWAYS(a_color, !done || color_ok, "result color is neither black nor white")

endmodule

bind mandelbrot_pixel_classifier_top mpc_top_props u_mpc_top_props (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.red    (red),
	.green  (green),
	.blue   (blue)
);
